// File: hdl/rtcsm_pkg.sv
`timescale 1ns / 1ps

package rtcsm_pkg;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [1:0] CFG_PHASE_TICKS = 2'd0;
  localparam logic [1:0] CFG_GUARD_TICKS = 2'd1;

  localparam logic [15:0] PHASE_TICKS_RESET = 16'd4;
  localparam logic [15:0] GUARD_TICKS_RESET = 16'd4;

  localparam logic [4:0] BYTE_BITS  = 5'd8;
  localparam logic [4:0] WRITE_BITS = 5'd16;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_GUARD_START,
    PH_SEND_LOW,
    PH_SEND_HIGH,
    PH_RECV_HIGH,
    PH_RECV_LOW,
    PH_GUARD_END
  } phase_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] address;
    logic [7:0] write_data;
    logic       data_pin;
  } rtcsm_in_t;

  typedef struct packed {
    logic       enable_pin;
    logic       clock_pin;
    logic       data_out_pin;
    logic       data_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
  } rtcsm_out_t;

  typedef struct packed {
    logic [15:0] phase_ticks;
    logic [15:0] guard_ticks;
  } rtcsm_cfg_t;

endpackage

// File: hdl/three_wire_rtc_serial_master.sv
`timescale 1ns / 1ps

// Three-wire serial master (enable, clock, shared data), least significant bit first.
// Every input beat is one timing tick or a start command and yields exactly one result
// beat showing the line levels after that tick, delivered through the output
// register; a new beat is taken every cycle unless a result waits under stall. Each clock
// half period lasts phase_ticks beats and enable is held guard_ticks beats before
// the first and after the last bit; a value of 0 counts as 1. A write takes
// 2*guard + 32*phase beats, a read 2*guard + 32*phase beats as well (8 sent bits and
// 8 received bits). Starts while busy are ordinary ticks. Configuration is written
// through cfg_index/cfg_data; indexes other than 0 and 1 are ignored.

module three_wire_rtc_serial_master
  import rtcsm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  rtcsm_in_t   in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output rtcsm_out_t  out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  rtcsm_cfg_t cfg_r;
  logic       out_valid_r;
  rtcsm_out_t out_data_r;
  rtcsm_out_t result;
  logic       in_accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  rtcsm_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (in_accept),
    .item   (in_data),
    .cfg    (cfg_r),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.phase_ticks <= PHASE_TICKS_RESET;
      cfg_r.guard_ticks <= GUARD_TICKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_PHASE_TICKS) begin
        cfg_r.phase_ticks <= cfg_data;
      end else if (cfg_index == CFG_GUARD_TICKS) begin
        cfg_r.guard_ticks <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: hdl/rtcsm_seq.sv
`timescale 1ns / 1ps

module rtcsm_seq
  import rtcsm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  rtcsm_in_t  item,
  input  rtcsm_cfg_t cfg,
  output rtcsm_out_t result
);

  phase_t      phase_r, phase_nxt;
  logic [4:0]  bit_count_r, bit_count_nxt;
  logic [15:0] send_shift_r, send_shift_nxt;
  logic [7:0]  receive_shift_r, receive_shift_nxt;
  logic [15:0] tick_count_r, tick_count_nxt;
  logic        is_read_r, is_read_nxt;
  logic [7:0]  last_read_r, last_read_nxt;
  logic        done;

  logic [15:0] len_raw;
  logic [15:0] len_eff;
  logic [16:0] tick_inc;
  logic        phase_end;
  logic [4:0]  send_limit;

  always_comb begin
    len_raw = ((phase_r == PH_GUARD_START) || (phase_r == PH_GUARD_END)) ?
              cfg.guard_ticks : cfg.phase_ticks;
    len_eff   = (len_raw == 16'd0) ? 16'd1 : len_raw;
    tick_inc  = {1'b0, tick_count_r} + 17'd1;
    phase_end = (tick_inc >= {1'b0, len_eff});
    send_limit = is_read_r ? BYTE_BITS : WRITE_BITS;
  end

  always_comb begin
    phase_nxt         = phase_r;
    bit_count_nxt     = bit_count_r;
    send_shift_nxt    = send_shift_r;
    receive_shift_nxt = receive_shift_r;
    tick_count_nxt    = tick_count_r;
    is_read_nxt       = is_read_r;
    last_read_nxt     = last_read_r;
    done              = 1'b0;
    if (step) begin
      if (phase_r == PH_IDLE) begin
        if ((item.command == CMD_WRITE) || (item.command == CMD_READ)) begin
          is_read_nxt       = (item.command == CMD_READ);
          send_shift_nxt    = (item.command == CMD_READ) ? {8'd0, item.address} :
                              {item.write_data, item.address};
          bit_count_nxt     = 5'd0;
          receive_shift_nxt = 8'd0;
          tick_count_nxt    = 16'd0;
          phase_nxt         = PH_GUARD_START;
        end
      end else if (phase_end) begin
        tick_count_nxt = 16'd0;
        case (phase_r)
          PH_GUARD_START: begin
            phase_nxt = PH_SEND_LOW;
          end
          PH_SEND_LOW: begin
            phase_nxt = PH_SEND_HIGH;
          end
          PH_SEND_HIGH: begin
            send_shift_nxt = {1'b0, send_shift_r[15:1]};
            bit_count_nxt  = bit_count_r + 5'd1;
            if (bit_count_nxt >= send_limit) begin
              if (is_read_r) begin
                bit_count_nxt = 5'd0;
                phase_nxt     = PH_RECV_HIGH;
              end else begin
                phase_nxt = PH_GUARD_END;
              end
            end else begin
              phase_nxt = PH_SEND_LOW;
            end
          end
          PH_RECV_HIGH: begin
            phase_nxt = PH_RECV_LOW;
          end
          PH_RECV_LOW: begin
            receive_shift_nxt = {item.data_pin, receive_shift_r[7:1]};
            bit_count_nxt     = bit_count_r + 5'd1;
            phase_nxt         = (bit_count_nxt >= BYTE_BITS) ? PH_GUARD_END : PH_RECV_HIGH;
          end
          PH_GUARD_END: begin
            if (is_read_r) begin
              last_read_nxt = receive_shift_r;
            end
            phase_nxt = PH_IDLE;
            done      = 1'b1;
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end else begin
        tick_count_nxt = tick_inc[15:0];
      end
    end
  end

  always_comb begin
    result.enable_pin   = 1'b0;
    result.clock_pin    = 1'b0;
    result.data_out_pin = 1'b0;
    result.data_drive   = 1'b0;
    case (phase_nxt)
      PH_GUARD_START: begin
        result.enable_pin = 1'b1;
        result.data_drive = 1'b1;
      end
      PH_SEND_LOW: begin
        result.enable_pin   = 1'b1;
        result.data_drive   = 1'b1;
        result.data_out_pin = send_shift_nxt[0];
      end
      PH_SEND_HIGH: begin
        result.enable_pin   = 1'b1;
        result.clock_pin    = 1'b1;
        result.data_drive   = 1'b1;
        result.data_out_pin = send_shift_nxt[0];
      end
      PH_RECV_HIGH: begin
        result.enable_pin = 1'b1;
        result.clock_pin  = 1'b1;
      end
      PH_RECV_LOW: begin
        result.enable_pin = 1'b1;
      end
      PH_GUARD_END: begin
        result.enable_pin = 1'b1;
        result.data_drive = !is_read_nxt;
      end
      default: begin
        result.enable_pin = 1'b0;
      end
    endcase
    result.busy_res  = (phase_nxt != PH_IDLE);
    result.done_res  = done;
    result.read_data = last_read_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_IDLE;
      bit_count_r     <= 5'd0;
      send_shift_r    <= 16'd0;
      receive_shift_r <= 8'd0;
      tick_count_r    <= 16'd0;
      is_read_r       <= 1'b0;
      last_read_r     <= 8'd0;
    end else begin
      phase_r         <= phase_nxt;
      bit_count_r     <= bit_count_nxt;
      send_shift_r    <= send_shift_nxt;
      receive_shift_r <= receive_shift_nxt;
      tick_count_r    <= tick_count_nxt;
      is_read_r       <= is_read_nxt;
      last_read_r     <= last_read_nxt;
    end
  end

endmodule

// File: hdl/rtcsm_checker.sv
`timescale 1ns / 1ps

module rtcsm_checker
  import rtcsm_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input rtcsm_out_t out_data
);

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res |-> !out_data.busy_res && !out_data.enable_pin)
    else $error("Transfer end beat still shows a busy bus.");

  a_idle_lines: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.busy_res |->
      !out_data.enable_pin && !out_data.clock_pin && !out_data.data_drive)
    else $error("Lines active outside a transfer.");

  a_clock_framed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.clock_pin |-> out_data.enable_pin)
    else $error("Serial clock high without enable.");

  a_dout_driven: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.data_out_pin |-> out_data.data_drive)
    else $error("Data level set while the line is released.");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Stalled result beat changed.");

endmodule

bind three_wire_rtc_serial_master rtcsm_checker u_rtcsm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
